// ===== design/spectrum_bin_smoothing_peak_hold_unit_defines.svh =====
// Assertion macros shared by the checker of the spectrum peak hold unit.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SPECTRUM_BIN_SMOOTHING_PEAK_HOLD_UNIT_DEFINES_SVH
`define SPECTRUM_BIN_SMOOTHING_PEAK_HOLD_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SBSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sbsp_pkg.sv =====
// Shared constants for the spectrum bin smoothing and peak hold unit.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package sbsp_pkg;

    // Default sizes
    localparam int DEF_NUM_BINS    = 513;
    localparam int DEF_LEVEL_WIDTH = 24;

    // Fixed field widths on the ports
    localparam int BIN_W        = 10;
    localparam int MAG_W        = 24;
    localparam int Q_W          = 16;
    localparam int CNT_W        = 16;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 64;
    localparam int OUT_PAD_W    = OUT_TDATA_W - BIN_W - 2 * MAG_W;
    localparam int IN_PAD_W     = IN_TDATA_W - BIN_W - MAG_W;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES  = 2'd1;

    localparam logic [Q_W-1:0]   DECAY_FACTOR_RST = 16'd58982;
    localparam logic [CNT_W-1:0] HOLD_FRAMES_RST  = 16'd20;

    // Q0.16 arithmetic constants
    localparam logic [Q_W-1:0] PEAK_DECAY_Q16 = 16'd64881;  // 0.99
    localparam logic [Q_W-1:0] Q16_HALF       = 16'd32768;

endpackage

`default_nettype wire

// ===== design/sbsp_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on an address collision. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module sbsp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 513,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/spectrum_bin_smoothing_peak_hold_unit.sv =====
// Spectrum bin smoothing and peak hold: per-bin release filter, peak hold and decay.
// Depends on sbsp_pkg (constants) and sbsp_ram (per-bin state store).
//
//  Channel   | Direction | Signals                              | Transfer when
//  ----------+-----------+--------------------------------------+-------------------------
//  s (input) | in        | i_s_tvalid, o_s_tready, i_s_tdata    | tvalid & tready high
//  m (output)| out       | o_m_tvalid, i_m_tready, o_m_tdata    | tvalid & tready high
//  cfg       | in        | i_cfg_we, i_cfg_index, i_cfg_wdata   | i_cfg_we high
//
//  One bin per cycle while the pipeline is not held; each result passes stages 1,
//  2 and 3 and then the output register. An item whose bin is still in one of the
//  three in-flight stages waits until that bin's state is written back, since the
//  release multiply closes the per-bin update loop.
//  After reset the state store is swept to zero, one bin per cycle; o_s_tready
//  stays low meanwhile, configuration writes are taken.
//  A one-entry skid stage behind the output register keeps input flowing while a
//  result waits; the pipeline holds only when the skid entry is occupied.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_bin_smoothing_peak_hold_unit #(
    parameter int NUM_BINS    = sbsp_pkg::DEF_NUM_BINS,
    parameter int LEVEL_WIDTH = sbsp_pkg::DEF_LEVEL_WIDTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // input stream
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // [9:0] bin_index, [33:10] magnitude, [39:34] zero
    input  wire logic [sbsp_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // output stream
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // [9:0] out_bin, [33:10] smoothed_level, [57:34] peak_level, [63:58] zero
    output logic      [sbsp_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // configuration writes
    input  wire logic                                 i_cfg_we,
    input  wire logic [sbsp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [sbsp_pkg::Q_W-1:0]             i_cfg_wdata
);

    localparam int BW     = sbsp_pkg::BIN_W;
    localparam int MW     = sbsp_pkg::MAG_W;
    localparam int QW     = sbsp_pkg::Q_W;
    localparam int CW     = sbsp_pkg::CNT_W;
    localparam int LW     = LEVEL_WIDTH;
    localparam int PW     = LW + QW;              // product width
    localparam int AW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int ENTRY_W = 2 * LW + CW;         // {count, peak, smooth}
    localparam int ODW    = sbsp_pkg::OUT_TDATA_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [QW-1:0] r_decay_factor;
    logic [CW-1:0] r_hold_frames;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_factor <= sbsp_pkg::DECAY_FACTOR_RST;
            r_hold_frames  <= sbsp_pkg::HOLD_FRAMES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sbsp_pkg::CFG_DECAY_FACTOR: r_decay_factor <= i_cfg_wdata;
                sbsp_pkg::CFG_HOLD_FRAMES:  r_hold_frames  <= i_cfg_wdata;
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clearing sweep after reset
    // ------------------------------------------------------------------
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(NUM_BINS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    // stage 1: item registered, store read data arrives
    logic          r_s1_valid;
    logic          r_s1_inr;
    logic [BW-1:0] r_s1_bin;
    logic [LW-1:0] r_s1_mag;
    // stage 2: compares done, multiplier operands ready
    logic          r_s2_valid;
    logic          r_s2_inr;
    logic [BW-1:0] r_s2_bin;
    logic [LW-1:0] r_s2_mag;
    logic          r_s2_srise;
    logic [LW-1:0] r_s2_diff;
    logic          r_s2_prise;
    logic          r_s2_pdecay;
    logic [LW-1:0] r_s2_pold;
    logic [CW-1:0] r_s2_cnt;
    // stage 3: products ready, final select and write-back
    logic          r_s3_valid;
    logic          r_s3_inr;
    logic [BW-1:0] r_s3_bin;
    logic [LW-1:0] r_s3_mag;
    logic          r_s3_srise;
    logic [PW-1:0] r_s3_prod_s;
    logic          r_s3_prise;
    logic          r_s3_pdecay;
    logic [LW-1:0] r_s3_pold;
    logic [PW-1:0] r_s3_prod_p;
    logic [CW-1:0] r_s3_cnt;
    // output register and skid entry
    logic           r_out_valid;
    logic [ODW-1:0] r_out_data;
    logic           r_sk_valid;
    logic [ODW-1:0] r_sk_data;

    // Advance the whole pipeline unless the skid entry is occupied.
    logic w_en;
    assign w_en = !r_sk_valid;

    // ------------------------------------------------------------------
    // Input side: hazard check and accept
    // ------------------------------------------------------------------
    logic [BW-1:0] w_in_bin;
    logic [LW-1:0] w_in_mag;
    logic          w_in_inr;
    logic          w_hazard;
    logic          w_accept;

    assign w_in_bin = i_s_tdata[BW-1:0];
    assign w_in_mag = LW'(i_s_tdata[BW +: MW]);
    assign w_in_inr = 32'(w_in_bin) < 32'(NUM_BINS);

    // Hold off an item whose bin is still being updated further down.
    assign w_hazard = (r_s1_valid && r_s1_inr && (r_s1_bin == w_in_bin))
                   || (r_s2_valid && r_s2_inr && (r_s2_bin == w_in_bin))
                   || (r_s3_valid && r_s3_inr && (r_s3_bin == w_in_bin));

    assign o_s_tready = w_en && !r_clr_busy && !w_hazard;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // ------------------------------------------------------------------
    // Per-bin state store
    // ------------------------------------------------------------------
    logic               w_ram_we;
    logic [AW-1:0]      w_ram_waddr;
    logic [ENTRY_W-1:0] w_ram_wdata;
    logic [ENTRY_W-1:0] w_ram_rdata;
    logic [ENTRY_W-1:0] w_wb_entry;

    assign w_ram_we    = r_clr_busy || (r_s3_valid && r_s3_inr && w_en);
    assign w_ram_waddr = r_clr_busy ? r_clr_addr : AW'(r_s3_bin);
    assign w_ram_wdata = r_clr_busy ? '0 : w_wb_entry;

    sbsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (AW'(w_in_bin)),
        .o_rdata (w_ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 -> 2: compare against stored levels, step the hold counter
    // ------------------------------------------------------------------
    logic [LW-1:0] w_s1_sold;
    logic [LW-1:0] w_s1_pold;
    logic [CW-1:0] w_s1_cold;
    logic [CW-1:0] w_s1_cdec;
    logic          w_s1_prise;

    assign w_s1_sold  = w_ram_rdata[LW-1:0];
    assign w_s1_pold  = w_ram_rdata[2*LW-1:LW];
    assign w_s1_cold  = w_ram_rdata[ENTRY_W-1:2*LW];
    assign w_s1_cdec  = (w_s1_cold != '0) ? (w_s1_cold - CW'(1)) : '0;
    assign w_s1_prise = r_s1_mag > w_s1_pold;

    // ------------------------------------------------------------------
    // Stage 3: round the release, pick the peak, build the result
    // ------------------------------------------------------------------
    logic [PW-1:0]  w_s3_round;
    logic [LW-1:0]  w_s3_snew;
    logic [LW-1:0]  w_s3_pnew;
    logic [ODW-1:0] w_s3_result;

    // s*d + m*(1-d) rewritten as m + (s-m)*d, exact since m*2^16 drops out of the round.
    assign w_s3_round = r_s3_prod_s + PW'(sbsp_pkg::Q16_HALF);
    assign w_s3_snew  = r_s3_srise ? r_s3_mag : (r_s3_mag + w_s3_round[PW-1:QW]);
    assign w_s3_pnew  = r_s3_prise  ? r_s3_mag :
                        r_s3_pdecay ? r_s3_prod_p[PW-1:QW] : r_s3_pold;
    assign w_wb_entry = {r_s3_cnt, w_s3_pnew, w_s3_snew};

    // Out-of-range bins report zero levels.
    assign w_s3_result = r_s3_inr
        ? {{sbsp_pkg::OUT_PAD_W{1'b0}}, MW'(w_s3_pnew), MW'(w_s3_snew), r_s3_bin}
        : {{sbsp_pkg::OUT_PAD_W{1'b0}}, {(2 * MW){1'b0}}, r_s3_bin};

    // ------------------------------------------------------------------
    // Stage valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage payloads
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_inr    <= w_in_inr;
            r_s1_bin    <= w_in_bin;
            r_s1_mag    <= w_in_mag;

            r_s2_inr    <= r_s1_inr;
            r_s2_bin    <= r_s1_bin;
            r_s2_mag    <= r_s1_mag;
            r_s2_srise  <= r_s1_mag > w_s1_sold;
            r_s2_diff   <= w_s1_sold - r_s1_mag;
            r_s2_prise  <= w_s1_prise;
            r_s2_pdecay <= (w_s1_cdec == '0);
            r_s2_pold   <= w_s1_pold;
            r_s2_cnt    <= w_s1_prise ? r_hold_frames : w_s1_cdec;

            r_s3_inr    <= r_s2_inr;
            r_s3_bin    <= r_s2_bin;
            r_s3_mag    <= r_s2_mag;
            r_s3_srise  <= r_s2_srise;
            r_s3_prod_s <= PW'(r_s2_diff) * PW'(r_decay_factor);
            r_s3_prise  <= r_s2_prise;
            r_s3_pdecay <= r_s2_pdecay;
            r_s3_pold   <= r_s2_pold;
            r_s3_prod_p <= PW'(r_s2_pold) * PW'(sbsp_pkg::PEAK_DECAY_Q16);
            r_s3_cnt    <= r_s2_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    logic w_out_free;
    logic w_s3_push;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_s3_push  = w_en && r_s3_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (w_out_free) begin
            // Refill from the skid entry first, else from the last stage.
            r_out_valid <= r_sk_valid || w_s3_push;
            r_sk_valid  <= 1'b0;
        end else if (w_s3_push) begin
            r_sk_valid  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= r_sk_valid ? r_sk_data : w_s3_result;
        end else if (w_s3_push) begin
            r_sk_data  <= w_s3_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== design/sbsp_checker.sv =====
// Port-level checker for the spectrum bin smoothing and peak hold unit, plus its bind.
// Depends on sbsp_pkg and the macros in spectrum_bin_smoothing_peak_hold_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "spectrum_bin_smoothing_peak_hold_unit_defines.svh"

module sbsp_checker #(
    parameter int NUM_BINS = sbsp_pkg::DEF_NUM_BINS
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_s_tvalid,
    input wire logic                                 o_s_tready,
    input wire logic [sbsp_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input wire logic                                 o_m_tvalid,
    input wire logic                                 i_m_tready,
    input wire logic [sbsp_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    localparam int BW = sbsp_pkg::BIN_W;
    localparam int MW = sbsp_pkg::MAG_W;

    logic w_in_xfer;
    logic w_in_inr;
    logic w_out_oor;

    assign w_in_xfer = i_s_tvalid && o_s_tready;
    assign w_in_inr  = 32'(i_s_tdata[BW-1:0]) < 32'(NUM_BINS);
    assign w_out_oor = 32'(o_m_tdata[BW-1:0]) >= 32'(NUM_BINS);

    // A stalled result holds its payload.
    `SBSP_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "output result changed while stalled")

    // Results for bins outside the store carry zero levels.
    `SBSP_ASSERT_SAME(a_oor_zero, o_m_tvalid && w_out_oor, o_m_tdata[BW +: 2 * MW] == '0, "out-of-range bin shows nonzero levels")

    // A bin still in flight is not taken again on the next cycle.
    `SBSP_ASSERT_NEXT(a_no_rmw_overlap, w_in_xfer && w_in_inr, !(w_in_xfer && (i_s_tdata[BW-1:0] == $past(i_s_tdata[BW-1:0]))), "same bin accepted on consecutive cycles")

endmodule

bind spectrum_bin_smoothing_peak_hold_unit sbsp_checker #(
    .NUM_BINS (NUM_BINS)
) u_sbsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// ===== bench/spectrum_bin_smoothing_peak_hold_unit_test.sv =====
// Self-checking bench for the spectrum bin smoothing and peak hold unit.
// Needs sbsp_pkg and the unit's RTL; drives both streams and the config port.
`timescale 1ns / 1ps

module spectrum_bin_smoothing_peak_hold_unit_test;

    localparam int BIN_W       = sbsp_pkg::BIN_W;
    localparam int MAG_W       = sbsp_pkg::MAG_W;
    localparam int Q_W         = sbsp_pkg::Q_W;
    localparam int CNT_W       = sbsp_pkg::CNT_W;
    localparam int CFG_IDX_W   = sbsp_pkg::CFG_IDX_W;
    localparam int IN_TDATA_W  = sbsp_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = sbsp_pkg::OUT_TDATA_W;
    localparam int IN_PAD_W    = sbsp_pkg::IN_PAD_W;

    localparam int NUM_BINS        = sbsp_pkg::DEF_NUM_BINS;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 194;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 8;

    // Register indexes with no register behind them; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [MAG_W-1:0] MAG_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [MAG_W-1:0] smooth;
        logic [MAG_W-1:0] peak;
    } t_bin_levels;

    // One directed step: an input item, or a register write (index in bin,
    // value in mag). Typed levels are used only when check is set.
    typedef struct packed {
        t_row_kind        kind;
        logic [BIN_W-1:0] bin;
        logic [MAG_W-1:0] mag;
        logic             check;
        logic [MAG_W-1:0] exp_smooth;
        logic [MAG_W-1:0] exp_peak;
    } t_dir_row;

    localparam int DIR_ROWS = 23;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // all-zero store after reset: zero in gives zero out
        '{ROW_ITEM, 10'd0,    24'd0,       1'b1, 24'd0,   24'd0},
        // full-scale rise: instant attack, new peak
        '{ROW_ITEM, 10'd0,    MAG_MAX,     1'b1, MAG_MAX, MAG_MAX},
        // equal magnitude counts as a fall, release of equal values holds
        '{ROW_ITEM, 10'd0,    MAG_MAX,     1'b1, MAG_MAX, MAG_MAX},
        '{ROW_ITEM, 10'd512,  MAG_MAX,     1'b1, MAG_MAX, MAG_MAX},
        // bins past the end: zero levels, store untouched
        '{ROW_ITEM, 10'd513,  24'h123456,  1'b1, 24'd0,   24'd0},
        '{ROW_ITEM, 10'd1023, MAG_MAX,     1'b1, 24'd0,   24'd0},
        '{ROW_ITEM, 10'd0,    24'd0,       1'b0, 24'd0,   24'd0},
        '{ROW_ITEM, 10'd1,    24'd1,       1'b1, 24'd1,   24'd1},
        '{ROW_ITEM, 10'd1,    24'd0,       1'b0, 24'd0,   24'd0},
        // writes to unmapped indexes
        '{ROW_CFG,  10'(CFG_SPARE_2),      24'h00FFFF, 1'b0, 24'd0, 24'd0},
        '{ROW_CFG,  10'(CFG_SPARE_3),      24'd0,      1'b0, 24'd0, 24'd0},
        // zero decay: a fall lands on the magnitude, peak still held
        '{ROW_CFG,  10'(sbsp_pkg::CFG_DECAY_FACTOR), 24'd0,      1'b0, 24'd0, 24'd0},
        '{ROW_ITEM, 10'd0,    24'd5,       1'b1, 24'd5,   MAG_MAX},
        '{ROW_CFG,  10'(sbsp_pkg::CFG_DECAY_FACTOR), 24'h00FFFF, 1'b0, 24'd0, 24'd0},
        '{ROW_ITEM, 10'd0,    24'd0,       1'b0, 24'd0,   24'd0},
        // hold of zero: peak decays on the very next non-raising item
        '{ROW_CFG,  10'(sbsp_pkg::CFG_HOLD_FRAMES),  24'd0,      1'b0, 24'd0, 24'd0},
        '{ROW_ITEM, 10'd2,    24'd1000,    1'b1, 24'd1000, 24'd1000},
        '{ROW_ITEM, 10'd2,    24'd1000,    1'b0, 24'd0,   24'd0},
        '{ROW_CFG,  10'(sbsp_pkg::CFG_HOLD_FRAMES),  24'h00FFFF, 1'b0, 24'd0, 24'd0},
        '{ROW_ITEM, 10'd3,    MAG_MAX,     1'b1, MAG_MAX, MAG_MAX},
        '{ROW_ITEM, 10'd3,    24'd0,       1'b0, 24'd0,   24'd0},
        // back to reset values
        '{ROW_CFG,  10'(sbsp_pkg::CFG_DECAY_FACTOR),
          24'(sbsp_pkg::DECAY_FACTOR_RST), 1'b0, 24'd0, 24'd0},
        '{ROW_CFG,  10'(sbsp_pkg::CFG_HOLD_FRAMES),
          24'(sbsp_pkg::HOLD_FRAMES_RST),  1'b0, 24'd0, 24'd0}
    };

    // DUT connections; every input starts at a known value
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_s_tvalid  = 1'b0;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata   = '0;
    logic                    o_m_tvalid;
    logic                    i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [Q_W-1:0]          i_cfg_wdata = '0;

    // Predictor state: per-bin levels, hold counters and the two registers
    logic [MAG_W-1:0] smooth_lvl [NUM_BINS];
    logic [MAG_W-1:0] peak_lvl   [NUM_BINS];
    logic [CNT_W-1:0] hold_cnt   [NUM_BINS];
    logic [Q_W-1:0]   decay_q16  = sbsp_pkg::DECAY_FACTOR_RST;
    logic [CNT_W-1:0] hold_load  = sbsp_pkg::HOLD_FRAMES_RST;

    // Levels still owed by the DUT, oldest first
    t_bin_levels levels_due [$];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_off_req   = 0;
    int hold_off_seen  = 0;
    int hold_off_left  = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;

    t_bin_levels seen_levels;
    t_bin_levels want_levels;

    spectrum_bin_smoothing_peak_hold_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance one bin through the release filter and peak hold, return its
    // new levels. Out-of-range bins leave the store alone and report zeros.
    function automatic t_bin_levels update_bin_levels(input logic [BIN_W-1:0] bin,
                                                      input logic [MAG_W-1:0] mag);
        t_bin_levels      res;
        logic [63:0]      acc;
        logic [MAG_W-1:0] s;
        logic [MAG_W-1:0] p;
        logic [CNT_W-1:0] cnt;
        res = '{bin: bin, smooth: '0, peak: '0};
        if (bin < NUM_BINS) begin
            s = smooth_lvl[bin];
            if (mag > s) begin
                s = mag;
            end else begin
                acc = 64'(s) * 64'(decay_q16) + 64'(mag) * (64'd65536 - 64'(decay_q16))
                    + 64'(sbsp_pkg::Q16_HALF);
                s = acc[16 +: MAG_W];
            end
            p   = peak_lvl[bin];
            cnt = hold_cnt[bin];
            if (mag > p) begin
                p   = mag;
                cnt = hold_load;
            end else begin
                if (cnt != 0) cnt = cnt - 1'b1;
                if (cnt == 0) begin
                    acc = 64'(p) * 64'(sbsp_pkg::PEAK_DECAY_Q16);
                    p = acc[16 +: MAG_W];
                end
            end
            smooth_lvl[bin] = s;
            peak_lvl[bin]   = p;
            hold_cnt[bin]   = cnt;
            res.smooth      = s;
            res.peak        = p;
        end
        return res;
    endfunction

    // Offer one item after a random gap, hold it until the transfer, then
    // queue its levels (typed ones where given). Returns on a falling edge.
    task automatic send_bin(input logic [BIN_W-1:0] bin, input logic [MAG_W-1:0] mag,
                            input logic use_typed, input t_bin_levels typed);
        t_bin_levels pred;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {IN_PAD_W'(0), mag, bin};
        do @(posedge i_clk); while (!o_s_tready);
        pred = update_bin_levels(bin, mag);
        levels_due.push_back(use_typed ? typed : pred);
        @(negedge i_clk);
    endtask

    // Drop valid, then step on falling edges, at least once, until every owed
    // result has come out.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (levels_due.size() != 0);
    endtask

    // Write one register with the unit idle, mirror it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] val);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            sbsp_pkg::CFG_DECAY_FACTOR: decay_q16 = val;
            sbsp_pkg::CFG_HOLD_FRAMES:  hold_load = val;
            default: ;
        endcase
    endtask

    // Receiver: stall at the phase's rate; on request, hold off for a long
    // stretch so the pipeline fills and back-pressures the input.
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_m_tready    <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else if (hold_off_req != hold_off_seen) begin
            hold_off_seen <= hold_off_req;
            hold_off_left <= HOLD_OFF_CYCLES - 1;
            i_m_tready    <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Check each output transfer against the oldest owed levels.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_levels.bin    = o_m_tdata[BIN_W-1:0];
            seen_levels.smooth = o_m_tdata[BIN_W +: MAG_W];
            seen_levels.peak   = o_m_tdata[BIN_W + MAG_W +: MAG_W];
            if (levels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: bin %0d smooth %h peak %h",
                             seen_levels.bin, seen_levels.smooth, seen_levels.peak);
            end else begin
                want_levels = levels_due.pop_front();
                if (seen_levels.bin !== want_levels.bin
                        || seen_levels.smooth !== want_levels.smooth
                        || seen_levels.peak !== want_levels.peak) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("exp bin %0d smooth %h peak %h, got bin %0d smooth %h peak %h",
                                 want_levels.bin, want_levels.smooth, want_levels.peak,
                                 seen_levels.bin, seen_levels.smooth, seen_levels.peak);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles with no transfer at all.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("spectrum_bin_smoothing_peak_hold_unit: mismatch");
            $finish;
        end
    end

    // Stimulus
    logic [BIN_W-1:0] rnd_bin;
    logic [MAG_W-1:0] rnd_mag;
    logic [Q_W-1:0]   ph_decay;
    logic [CNT_W-1:0] ph_hold;
    t_bin_levels      typed_levels;
    t_dir_row         row;
    t_idle_mode       mode;
    int               pick;

    initial begin
        for (int b = 0; b < NUM_BINS; b++) begin
            smooth_lvl[b] = '0;
            peak_lvl[b]   = '0;
            hold_cnt[b]   = '0;
        end

        // Hold reset low at the start; the store sweep that follows keeps
        // tready low, so the first transfer simply waits it out.
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, no idling on either side
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TABLE[r];
            if (row.kind == ROW_CFG) begin
                write_reg(row.bin[CFG_IDX_W-1:0], row.mag[Q_W-1:0]);
            end else begin
                typed_levels = '{bin: row.bin, smooth: row.exp_smooth, peak: row.exp_peak};
                send_bin(row.bin, row.mag, row.check, typed_levels);
            end
        end

        // Random phases: walk the idle modes, change both registers each time
        for (int ph = 0; ph < PHASES; ph++) begin
            mode = t_idle_mode'(ph % 4);
            case (mode)
                IDLE_NONE: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SEND: begin send_gap_pct = 81; recv_stall_pct = 0;  end
                IDLE_RECV: begin send_gap_pct = 0;  recv_stall_pct = 81; end
                default:   begin send_gap_pct = 13; recv_stall_pct = 13; end
            endcase
            case (ph)
                0: begin
                    ph_decay = sbsp_pkg::DECAY_FACTOR_RST;
                    ph_hold  = sbsp_pkg::HOLD_FRAMES_RST;
                end
                1:       begin ph_decay = '0;               ph_hold = '0;              end
                2:       begin ph_decay = '1;               ph_hold = '1;              end
                3:       begin ph_decay = Q_W'($urandom);   ph_hold = CNT_W'($urandom_range(1, 5)); end
                4:       begin ph_decay = sbsp_pkg::Q16_HALF; ph_hold = 16'd3;         end
                5:       begin ph_decay = Q_W'($urandom);   ph_hold = CNT_W'($urandom_range(0, 40)); end
                6:       begin ph_decay = '1;               ph_hold = '0;              end
                default: begin
                    ph_decay = Q_W'($urandom);
                    ph_hold  = sbsp_pkg::HOLD_FRAMES_RST;
                end
            endcase
            write_reg(sbsp_pkg::CFG_DECAY_FACTOR, ph_decay);
            write_reg(sbsp_pkg::CFG_HOLD_FRAMES, ph_hold);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Stall the receiver for a long stretch while items keep coming
                if (ph == 4 && n == 40) hold_off_req = hold_off_req + 1;
                // Pause the sender until everything owed has come out
                if (ph == 5 && n == 100) wait_drained();

                // Mostly a handful of bins so peaks get held and decay;
                // some full range and some past the end.
                pick = $urandom_range(0, 99);
                if (pick < 70)      rnd_bin = BIN_W'($urandom_range(0, 7));
                else if (pick < 90) rnd_bin = BIN_W'($urandom_range(0, NUM_BINS - 1));
                else if (pick < 95) rnd_bin = (pick[0]) ? BIN_W'(NUM_BINS - 1) : '0;
                else                rnd_bin = BIN_W'($urandom_range(NUM_BINS, 1023));

                // Falling magnitudes dominate; equal-to-level values hit the
                // tie cases.
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    rnd_mag = '0;
                else if (pick < 20)
                    rnd_mag = MAG_MAX;
                else if (pick < 30 && rnd_bin < NUM_BINS)
                    rnd_mag = peak_lvl[rnd_bin];
                else if (pick < 40 && rnd_bin < NUM_BINS)
                    rnd_mag = smooth_lvl[rnd_bin];
                else if (pick < 75)
                    rnd_mag = MAG_W'($urandom) >> $urandom_range(0, MAG_W - 1);
                else
                    rnd_mag = MAG_W'($urandom);

                send_bin(rnd_bin, rnd_mag, 1'b0, '0);
            end
        end

        // Drain, then let the pipeline settle before the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && levels_due.size() == 0)
            $display("spectrum_bin_smoothing_peak_hold_unit: match");
        else
            $display("spectrum_bin_smoothing_peak_hold_unit: mismatch");
        $finish;
    end

endmodule
